@@ rtl/core/lrupr_pkg.sv @@
// Shared constants for the LRU page replacement core.
package lrupr_pkg;

  localparam int MAX_FRAMES_DEF = 8;
  localparam int PAGE_BITS_DEF  = 16;

  localparam int CFG_W     = 4;
  localparam int CFG_RESET = 4;
  localparam int TOTAL_W   = 32;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;
  localparam int QUEUE_DEPTH = 2;

  // register index, taken from paddr[APB_AW-1:2]
  localparam logic [APB_AW-3:0] REG_FRAMES_IN_USE = '0;

endpackage

@@ rtl/core/lrupr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lrupr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/lrupr_fifo.sv @@
// Short queue between the classify front end and the replacement engine.
module lrupr_fifo #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt;
  logic [PW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule

@@ rtl/core/lrupr_front.sv @@
// Front end: config register, input beat acceptance and frame-count classification.
module lrupr_front #(
  parameter int MAX_FRAMES = lrupr_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = lrupr_pkg::PAGE_BITS_DEF,
  parameter int SLOT_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
  parameter int QW         = PAGE_BITS + 1 + SLOT_W
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lrupr_pkg::APB_AW-1:0] paddr,
  input  logic [lrupr_pkg::APB_DW-1:0] pwdata,
  output logic [lrupr_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid,
  input  logic [PAGE_BITS-1:0]        in_page_number,
  input  logic                        in_last_ref,
  output logic                        in_stall,
  output logic                        q_push,
  output logic [QW-1:0]               q_data,
  input  logic                        q_full
);
  import lrupr_pkg::*;

  logic [CFG_W-1:0]  frames_r, frames_nxt;
  logic              reg_sel;
  logic [SLOT_W-1:0] last_idx;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[APB_AW-1:2] == REG_FRAMES_IN_USE);
  assign prdata  = reg_sel ? APB_DW'(frames_r) : '0;

  always_comb begin
    frames_nxt = frames_r;
    if (psel && penable && pwrite && pready && reg_sel) begin
      frames_nxt = pwdata[CFG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_r <= CFG_W'(CFG_RESET);
    end else begin
      frames_r <= frames_nxt;
    end
  end

  // highest frame index taking part: count clamped to 1..MAX_FRAMES
  always_comb begin
    if (frames_r == '0) begin
      last_idx = '0;
    end else if (32'(frames_r) > 32'(MAX_FRAMES)) begin
      last_idx = SLOT_W'(MAX_FRAMES - 1);
    end else begin
      last_idx = SLOT_W'(32'(frames_r) - 32'd1);
    end
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign q_data   = {in_page_number, in_last_ref, last_idx};

endmodule

@@ rtl/core/lrupr_back.sv @@
// Replacement engine: frame scan, victim pick, recency update and result register.
module lrupr_back #(
  parameter int MAX_FRAMES = lrupr_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = lrupr_pkg::PAGE_BITS_DEF,
  parameter int SLOT_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
  parameter int QW         = PAGE_BITS + 1 + SLOT_W
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  logic [QW-1:0]                 q_data,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_hit,
  output logic [SLOT_W-1:0]             out_frame_slot,
  output logic                          out_evicted_valid,
  output logic [PAGE_BITS-1:0]          out_evicted_page,
  output logic [lrupr_pkg::TOTAL_W-1:0] out_hit_total,
  output logic [lrupr_pkg::TOTAL_W-1:0] out_fault_total,
  output logic                          out_run_done
);
  import lrupr_pkg::*;

  localparam logic [SLOT_W-1:0] AGE_MAX = SLOT_W'(MAX_FRAMES - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_UPD  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // current item
  logic [PAGE_BITS-1:0] page_r;
  logic                 last_r;
  logic [SLOT_W-1:0]    last_idx_r;
  logic [SLOT_W-1:0]    idx_r, idx_nxt;

  // scan tracking
  logic                 hit_r, hit_nxt;
  logic [SLOT_W-1:0]    hit_slot_r;
  logic [SLOT_W-1:0]    hit_age_r;
  logic                 empty_fnd_r, empty_fnd_nxt;
  logic [SLOT_W-1:0]    empty_slot_r;
  logic [SLOT_W-1:0]    best_age_r;
  logic [SLOT_W-1:0]    victim_r;
  logic [PAGE_BITS-1:0] victim_page_r;

  // frame state
  logic [MAX_FRAMES-1:0] valid_r, valid_nxt;
  logic [SLOT_W-1:0]     age_r [MAX_FRAMES];
  logic [SLOT_W-1:0]     age_nxt [MAX_FRAMES];
  logic [TOTAL_W-1:0]    hits_r, hits_nxt;
  logic [TOTAL_W-1:0]    faults_r, faults_nxt;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic                 o_hit_r;
  logic [SLOT_W-1:0]    o_slot_r;
  logic                 o_ev_valid_r;
  logic [PAGE_BITS-1:0] o_ev_page_r;
  logic [TOTAL_W-1:0]   o_hits_r, o_faults_r;
  logic                 o_done_r;

  logic [SLOT_W-1:0]    ram_raddr;
  logic [PAGE_BITS-1:0] ram_rdata;
  logic                 ram_we;

  logic                 out_free, upd_go, hit_now, scan_end;
  logic [SLOT_W-1:0]    slot;
  logic                 ev_valid;
  logic [SLOT_W-1:0]    cur_age;

  assign out_free = !out_valid_r || !out_stall;
  assign upd_go   = (state_r == ST_UPD) && out_free;
  assign cur_age  = age_r[idx_r];
  assign hit_now  = valid_r[idx_r] && (ram_rdata == page_r);
  assign scan_end = hit_now || (idx_r == last_idx_r);
  assign q_pop    = (state_r == ST_IDLE) && !q_empty;

  assign slot     = hit_r ? hit_slot_r : (empty_fnd_r ? empty_slot_r : victim_r);
  assign ev_valid = !hit_r && !empty_fnd_r;
  assign ram_we   = upd_go && !hit_r;

  always_comb begin
    ram_raddr = '0;
    if (state_r == ST_SCAN) begin
      ram_raddr = (idx_r == last_idx_r) ? idx_r : idx_r + 1'b1;
    end
  end

  lrupr_ram #(
    .WIDTH (PAGE_BITS),
    .DEPTH (MAX_FRAMES),
    .AW    (SLOT_W)
  ) u_page_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (page_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    hit_nxt       = hit_r;
    empty_fnd_nxt = empty_fnd_r;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          state_nxt     = ST_SCAN;
          idx_nxt       = '0;
          hit_nxt       = 1'b0;
          empty_fnd_nxt = 1'b0;
        end
      end
      ST_SCAN: begin
        if (hit_now) begin
          hit_nxt = 1'b1;
        end
        if (!empty_fnd_r && !valid_r[idx_r]) begin
          empty_fnd_nxt = 1'b1;
        end
        if (scan_end) begin
          state_nxt = ST_UPD;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_UPD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // recency, valid and totals
  always_comb begin
    valid_nxt  = valid_r;
    hits_nxt   = hits_r;
    faults_nxt = faults_r;
    for (int f = 0; f < MAX_FRAMES; f++) begin
      age_nxt[f] = age_r[f];
    end
    if (upd_go) begin
      if (last_r) begin
        valid_nxt  = '0;
        hits_nxt   = '0;
        faults_nxt = '0;
        for (int f = 0; f < MAX_FRAMES; f++) begin
          age_nxt[f] = '0;
        end
      end else begin
        if (hit_r) begin
          hits_nxt = (&hits_r) ? hits_r : hits_r + 1'b1;
        end else begin
          faults_nxt = (&faults_r) ? faults_r : faults_r + 1'b1;
        end
        valid_nxt[slot] = 1'b1;
        for (int f = 0; f < MAX_FRAMES; f++) begin
          if (SLOT_W'(f) == slot) begin
            age_nxt[f] = '0;
          end else if ((SLOT_W'(f) <= last_idx_r) && valid_r[f] &&
                       (!hit_r || (age_r[f] < hit_age_r)) && (age_r[f] < AGE_MAX)) begin
            age_nxt[f] = age_r[f] + 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (upd_go) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      hit_r       <= 1'b0;
      empty_fnd_r <= 1'b0;
      valid_r     <= '0;
      hits_r      <= '0;
      faults_r    <= '0;
      out_valid_r <= 1'b0;
      for (int f = 0; f < MAX_FRAMES; f++) begin
        age_r[f] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      hit_r       <= hit_nxt;
      empty_fnd_r <= empty_fnd_nxt;
      valid_r     <= valid_nxt;
      hits_r      <= hits_nxt;
      faults_r    <= faults_nxt;
      out_valid_r <= out_valid_nxt;
      for (int f = 0; f < MAX_FRAMES; f++) begin
        age_r[f] <= age_nxt[f];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      {page_r, last_r, last_idx_r} <= q_data;
    end
    if (state_r == ST_SCAN) begin
      if (hit_now) begin
        hit_slot_r <= idx_r;
        hit_age_r  <= cur_age;
      end
      if (!empty_fnd_r && !valid_r[idx_r]) begin
        empty_slot_r <= idx_r;
      end
      // strict compare keeps the lowest frame on equal ages
      if ((idx_r == '0) || (cur_age > best_age_r)) begin
        best_age_r    <= cur_age;
        victim_r      <= idx_r;
        victim_page_r <= ram_rdata;
      end
    end
    if (upd_go) begin
      o_hit_r      <= hit_r;
      o_slot_r     <= slot;
      o_ev_valid_r <= ev_valid;
      o_ev_page_r  <= ev_valid ? victim_page_r : '0;
      o_hits_r     <= hit_r ? ((&hits_r) ? hits_r : hits_r + 1'b1) : hits_r;
      o_faults_r   <= hit_r ? faults_r : ((&faults_r) ? faults_r : faults_r + 1'b1);
      o_done_r     <= last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = o_hit_r;
  assign out_frame_slot    = o_slot_r;
  assign out_evicted_valid = o_ev_valid_r;
  assign out_evicted_page  = o_ev_page_r;
  assign out_hit_total     = o_hits_r;
  assign out_fault_total   = o_faults_r;
  assign out_run_done      = o_done_r;

endmodule

@@ rtl/core/lru_page_replacement_core.sv @@
// LRU page replacement frame table. Each input beat is one page reference; each
// result beat reports hit or fault, the frame used, any evicted page and the running
// saturating hit and fault totals. The front end accepts beats into a two-entry queue
// and stalls only when that queue is full. The replacement engine finishes one reference
// before it pops the next: a pop step that starts the frame-page RAM read, a scan step
// for each of the n frames in use (1 to MAX_FRAMES; the scan stops at a hit), and an
// update step that waits while a pending result is stalled. The scan over the page RAM
// sets the time per reference. frames_in_use sits at byte address 0 and may only be
// written while the block is idle. No clearing pass follows reset; after a beat with
// last_ref set, the frames and totals clear.
module lru_page_replacement_core #(
  parameter int MAX_FRAMES = lrupr_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = lrupr_pkg::PAGE_BITS_DEF,
  parameter int SLOT_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lrupr_pkg::APB_AW-1:0]  paddr,
  input  logic [lrupr_pkg::APB_DW-1:0]  pwdata,
  output logic [lrupr_pkg::APB_DW-1:0]  prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [PAGE_BITS-1:0]          in_page_number,
  input  logic                          in_last_ref,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_hit,
  output logic [SLOT_W-1:0]             out_frame_slot,
  output logic                          out_evicted_valid,
  output logic [PAGE_BITS-1:0]          out_evicted_page,
  output logic [lrupr_pkg::TOTAL_W-1:0] out_hit_total,
  output logic [lrupr_pkg::TOTAL_W-1:0] out_fault_total,
  output logic                          out_run_done
);
  import lrupr_pkg::*;

  localparam int QW = PAGE_BITS + 1 + SLOT_W;

  logic          q_push, q_full, q_pop, q_empty;
  logic [QW-1:0] q_wdata, q_rdata;

  lrupr_front #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS),
    .SLOT_W     (SLOT_W),
    .QW         (QW)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_page_number (in_page_number),
    .in_last_ref    (in_last_ref),
    .in_stall       (in_stall),
    .q_push         (q_push),
    .q_data         (q_wdata),
    .q_full         (q_full)
  );

  lrupr_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  lrupr_back #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS),
    .SLOT_W     (SLOT_W),
    .QW         (QW)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_data            (q_rdata),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit           (out_hit),
    .out_frame_slot    (out_frame_slot),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_hit_total     (out_hit_total),
    .out_fault_total   (out_fault_total),
    .out_run_done      (out_run_done)
  );

endmodule
